// File: hw/rtl/bse_pkg.sv
// bse_pkg: shared constants, controller states and the command and status
// structs used between the byte sort controller and its datapath.
// no dependencies
package bse_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS_START,
    ST_PASS_FIRST,
    ST_PASS_RUN,
    ST_PASS_END,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic pass_start;
    logic pass_first;
    logic pass_run;
    logic pass_end;
    logic emit_load;
    logic emit_take;
  } cmd_t;

  typedef struct packed {
    logic short_block;
    logic run_more;
    logic pass_more;
    logic emit_final;
  } status_t;

endpackage

// File: hw/rtl/bse_ram.sv
// bse_ram: generic single write port, single read port ram with registered read
// no dependencies
module bse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/bse_ctrl.sv
// bse_ctrl: state machine sequencing load, bubble sort passes and emission
// depends on bse_pkg
module bse_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             last,
  input  logic             result_stall,
  input  bse_pkg::status_t status,
  output logic             item_stall,
  output bse_pkg::cmd_t    cmd
);

  bse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bse_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bse_pkg::ST_LOAD: begin
        if (item_valid && last) begin
          state_next = status.short_block ? bse_pkg::ST_EMIT_READ : bse_pkg::ST_PASS_START;
        end
      end
      bse_pkg::ST_PASS_START: state_next = bse_pkg::ST_PASS_FIRST;
      bse_pkg::ST_PASS_FIRST: state_next = bse_pkg::ST_PASS_RUN;
      bse_pkg::ST_PASS_RUN: begin
        if (!status.run_more) begin
          state_next = bse_pkg::ST_PASS_END;
        end
      end
      bse_pkg::ST_PASS_END: begin
        state_next = status.pass_more ? bse_pkg::ST_PASS_START : bse_pkg::ST_EMIT_READ;
      end
      bse_pkg::ST_EMIT_READ: state_next = bse_pkg::ST_EMIT_LOAD;
      bse_pkg::ST_EMIT_LOAD: state_next = bse_pkg::ST_EMIT_WAIT;
      bse_pkg::ST_EMIT_WAIT: begin
        if (!result_stall) begin
          state_next = status.emit_final ? bse_pkg::ST_LOAD : bse_pkg::ST_EMIT_READ;
        end
      end
      default: state_next = bse_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    item_stall     = (state != bse_pkg::ST_LOAD);
    cmd            = '0;
    cmd.load       = (state == bse_pkg::ST_LOAD) && item_valid;
    cmd.pass_start = (state == bse_pkg::ST_PASS_START);
    cmd.pass_first = (state == bse_pkg::ST_PASS_FIRST);
    cmd.pass_run   = (state == bse_pkg::ST_PASS_RUN);
    cmd.pass_end   = (state == bse_pkg::ST_PASS_END);
    cmd.emit_load  = (state == bse_pkg::ST_EMIT_LOAD);
    cmd.emit_take  = (state == bse_pkg::ST_EMIT_WAIT) && !result_stall;
  end

endmodule

// File: hw/rtl/bse_datapath.sv
// bse_datapath: element store, counters, compare and swap unit, result register
// depends on bse_pkg and bse_ram
module bse_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  bse_pkg::cmd_t                     cmd,
  input  logic signed [bse_pkg::DATA_W-1:0] value,
  output bse_pkg::status_t                  status,
  output logic signed [bse_pkg::DATA_W-1:0] sorted_value,
  output logic                              end_of_block,
  output logic                              overflow,
  output logic                              result_valid
);

  logic [bse_pkg::CNT_W-1:0]         count;
  logic                              dropped;
  logic [bse_pkg::CNT_W-1:0]         m;
  logic [bse_pkg::CNT_W-1:0]         k;
  logic signed [bse_pkg::DATA_W-1:0] hold;

  logic                              full;
  logic [bse_pkg::CNT_W-1:0]         n_after;
  logic                              we;
  logic [bse_pkg::ADDR_W-1:0]        waddr;
  logic [bse_pkg::DATA_W-1:0]        wdata;
  logic [bse_pkg::ADDR_W-1:0]        raddr;
  logic [bse_pkg::DATA_W-1:0]        rdata;
  logic signed [bse_pkg::DATA_W-1:0] rdata_s;
  logic                              gt;

  assign full    = (count == bse_pkg::CNT_W'(bse_pkg::CAPACITY));
  assign n_after = full ? count : count + bse_pkg::CNT_W'(1);
  assign rdata_s = $signed(rdata);
  assign gt      = (hold > rdata_s);

  assign status.short_block = (n_after < bse_pkg::CNT_W'(2));
  assign status.run_more    = ((k + bse_pkg::CNT_W'(1)) < m);
  assign status.pass_more   = (m >= bse_pkg::CNT_W'(3));
  assign status.emit_final  = end_of_block;

  always_comb begin
    we    = 1'b0;
    waddr = count[bse_pkg::ADDR_W-1:0];
    wdata = value;
    raddr = k[bse_pkg::ADDR_W-1:0];
    priority if (cmd.load) begin
      we = !full;
    end else if (cmd.pass_start) begin
      raddr = '0;
    end else if (cmd.pass_first) begin
      raddr = bse_pkg::ADDR_W'(1);
    end else if (cmd.pass_run) begin
      we    = 1'b1;
      waddr = k[bse_pkg::ADDR_W-1:0] - bse_pkg::ADDR_W'(1);
      wdata = gt ? rdata_s : hold;
      raddr = k[bse_pkg::ADDR_W-1:0] + bse_pkg::ADDR_W'(1);
    end else if (cmd.pass_end) begin
      we    = 1'b1;
      waddr = m[bse_pkg::ADDR_W-1:0] - bse_pkg::ADDR_W'(1);
      wdata = hold;
    end else begin
      raddr = k[bse_pkg::ADDR_W-1:0];
    end
  end

  bse_ram #(
    .WIDTH(bse_pkg::DATA_W),
    .DEPTH(bse_pkg::CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
      m            <= '0;
      k            <= '0;
    end else begin
      if (cmd.load) begin
        m <= n_after;
        k <= '0;
        if (full) begin
          dropped <= 1'b1;
        end else begin
          count <= n_after;
        end
      end
      if (cmd.pass_first) begin
        k <= bse_pkg::CNT_W'(1);
      end
      if (cmd.pass_run && status.run_more) begin
        k <= k + bse_pkg::CNT_W'(1);
      end
      if (cmd.pass_end) begin
        m <= m - bse_pkg::CNT_W'(1);
        k <= '0;
      end
      if (cmd.emit_load) begin
        result_valid <= 1'b1;
      end
      if (cmd.emit_take) begin
        result_valid <= 1'b0;
        if (end_of_block) begin
          count   <= '0;
          dropped <= 1'b0;
          k       <= '0;
        end else begin
          k <= k + bse_pkg::CNT_W'(1);
        end
      end
    end
  end

  // compare and swap: the larger value rides along the pass
  always_ff @(posedge clk) begin
    if (cmd.pass_first) begin
      hold <= rdata_s;
    end else if (cmd.pass_run && !gt) begin
      hold <= rdata_s;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      sorted_value <= rdata_s;
      end_of_block <= ((k + bse_pkg::CNT_W'(1)) == count);
      overflow     <= dropped;
    end
  end

endmodule

// File: hw/rtl/byte_sort_engine.sv
// byte_sort_engine: top level joining the sort controller and datapath
// depends on bse_pkg, bse_ctrl, bse_datapath
//
// usage:
//   input channel (value, last) loads signed bytes into a 64 entry store, one
//   transaction per cycle while loading; the transaction with last set closes
//   the block. elements past 64 are dropped and the block is flagged overflow.
//   after the closing transaction item_stall stays high while the store is
//   sorted in place by bubble sort passes over the ram (one read and one
//   write port); each pass over m elements carries the largest to the top
//   and the next pass covers m - 1 elements, down to a pass over two.
//   results (sorted_value, end_of_block, overflow) then leave smallest first;
//   each result needs a ram read, a load of the output register and its
//   transaction, and the next ram read waits for that transaction.
//   result_stall holds the output register and pauses the block; nothing is
//   lost. after the transaction with end_of_block set the block takes new
//   input at once. reset empties the store count, clears the dropped-element
//   flag and drops any result in flight.
module byte_sort_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [bse_pkg::DATA_W-1:0] value,
  input  logic                              last,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic signed [bse_pkg::DATA_W-1:0] sorted_value,
  output logic                              end_of_block,
  output logic                              overflow
);

  bse_pkg::cmd_t    cmd;
  bse_pkg::status_t status;

  bse_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .last        (last),
    .result_stall(result_stall),
    .status      (status),
    .item_stall  (item_stall),
    .cmd         (cmd)
  );

  bse_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .value       (value),
    .status      (status),
    .sorted_value(sorted_value),
    .end_of_block(end_of_block),
    .overflow    (overflow),
    .result_valid(result_valid)
  );

endmodule

// File: sim/byte_sort_engine_test.sv
// byte_sort_engine_test: self-checking bench for the byte sort engine, with random
// idling on both channels and an in-bench sort model that predicts each block's output
// depends on bse_pkg and byte_sort_engine
`timescale 1ns / 100ps

module byte_sort_engine_test;

  typedef struct packed {
    logic signed [bse_pkg::DATA_W-1:0] value;
    logic                              last;
  } elem_in_t;

  typedef struct packed {
    logic signed [bse_pkg::DATA_W-1:0] value;
    logic                              eob;
    logic                              ovf;
  } sorted_out_t;

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [bse_pkg::DATA_W-1:0] value = '0;
  logic last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [bse_pkg::DATA_W-1:0] sorted_value;
  logic end_of_block;
  logic overflow;

  elem_in_t    pending_elems[$];
  sorted_out_t sorted_expected[$];

  logic signed [bse_pkg::DATA_W-1:0] held[bse_pkg::CAPACITY];
  int  stored = 0;
  logic spilled = 1'b0;

  int  item_total = 0;
  int  cycle_count = 0;
  int  mismatch_count = 0;
  int  results_checked = 0;
  int  blocks_closed = 0;
  int  overflow_blocks = 0;
  logic item_taken;

  byte_sort_engine dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_value (sorted_value),
    .end_of_block (end_of_block),
    .overflow     (overflow)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // no idling inside the quiet window
  function automatic logic idle_gap();
    if (cycle_count >= 1500 && cycle_count < 5000) return 1'b0;
    return $urandom_range(0, 99) < 9;
  endfunction

  // stores or drops one element; a closing element yields the sorted block
  function automatic void absorb_element(logic signed [bse_pkg::DATA_W-1:0] v, logic closing);
    logic signed [bse_pkg::DATA_W-1:0] tmp;
    sorted_out_t r;
    int i;
    int j;
    if (stored < bse_pkg::CAPACITY) begin
      held[stored] = v;
      stored++;
    end else begin
      spilled = 1'b1;
    end
    if (!closing) return;
    for (i = 1; i < stored; i++) begin
      tmp = held[i];
      j = i - 1;
      while (j >= 0 && held[j] > tmp) begin
        held[j + 1] = held[j];
        j--;
      end
      held[j + 1] = tmp;
    end
    for (i = 0; i < stored; i++) begin
      r.value = held[i];
      r.eob   = (i == stored - 1);
      r.ovf   = spilled;
      sorted_expected.push_back(r);
    end
    blocks_closed++;
    if (spilled) overflow_blocks++;
    stored  = 0;
    spilled = 1'b0;
  endfunction

  task automatic queue_item(input logic signed [bse_pkg::DATA_W-1:0] v, input logic l);
    elem_in_t e;
    e.value = v;
    e.last  = l;
    pending_elems.push_back(e);
    item_total++;
  endtask

  // random block content, biased toward extremes and repeats
  task automatic queue_block(input int n);
    logic signed [bse_pkg::DATA_W-1:0] v;
    int k;
    v = '0;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 15))
        0:       v = -8'sd128;
        1:       v = 8'sd127;
        2:       v = 8'sd0;
        3:       v = -8'sd1;
        4:       v = v;
        default: v = 8'($urandom());
      endcase
      queue_item(v, k == n - 1);
    end
  endtask

  // driver
  always @(negedge clk) begin
    elem_in_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_taken) begin
      if (pending_elems.size() != 0 && !idle_gap()) begin
        nxt = pending_elems.pop_front();
        item_valid <= 1'b1;
        value      <= nxt.value;
        last       <= nxt.last;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= rst ? 1'b0 : idle_gap();
  end

  // monitor
  always @(posedge clk) begin
    sorted_out_t exp_r;
    cycle_count++;
    item_taken = !rst && item_valid && !item_stall;
    if (item_taken) absorb_element(value, last);
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (sorted_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transaction: value %0d eob %b ovf %b",
                   sorted_value, end_of_block, overflow);
      end else begin
        exp_r = sorted_expected.pop_front();
        results_checked++;
        if (sorted_value !== exp_r.value || end_of_block !== exp_r.eob ||
            overflow !== exp_r.ovf) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected value %0d eob %b ovf %b, got %0d %b %b",
                     exp_r.value, exp_r.eob, exp_r.ovf,
                     sorted_value, end_of_block, overflow);
        end
      end
    end
  end

  initial begin
    int n;
    int r;
    // single elements at both extremes, then both extremes as a pair
    queue_item(8'sd127, 1'b1);
    queue_item(-8'sd128, 1'b1);
    queue_item(8'sd127, 1'b0);
    queue_item(-8'sd128, 1'b1);
    // mixed signs, repeats and alternating bit patterns
    queue_item(-8'sd1, 1'b0);
    queue_item(8'sd1, 1'b0);
    queue_item(8'sd0, 1'b0);
    queue_item(-8'sd128, 1'b0);
    queue_item(8'sd127, 1'b0);
    queue_item(-8'sd1, 1'b0);
    queue_item(8'sd85, 1'b0);
    queue_item(-8'sd86, 1'b1);
    // already ascending
    for (n = -3; n <= 2; n++) queue_item(n[bse_pkg::DATA_W-1:0], n == 2);
    // all equal
    for (n = 0; n < 4; n++) queue_item(8'sd5, n == 3);

    // exactly full, then one over so the closing element is dropped
    queue_block(bse_pkg::CAPACITY);
    queue_block(bse_pkg::CAPACITY + 1);
    while (item_total < 380) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        n = $urandom_range(bse_pkg::CAPACITY, bse_pkg::CAPACITY + 6);
      else if (r < 12)
        n = $urandom_range(13, 40);
      else
        n = $urandom_range(1, 12);
      queue_block(n);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (pending_elems.size() != 0 || item_valid || sorted_expected.size() != 0);
    repeat (40) @(negedge clk);

    $display("sorted %0d elements in %0d blocks, %0d blocks with dropped elements",
             item_total, blocks_closed, overflow_blocks);
    $display("%0d result transactions checked, %0d mismatches",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still expected", sorted_expected.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
